/* hdl/circle_pair_collision_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the disc pair collision block
// Shorthand for clocked concurrent checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_COLLISION_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_ASSERT_SVH

// expression must hold at every clock edge
`define CPC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CPC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cpc_pkg.sv */
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, constants and helpers of the disc pair collision pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpc_pkg;

    // fixed point constants
    localparam int unsigned Q16_ONE           = 65536;
    localparam int unsigned DEGEN_D2          = 43;
    localparam int unsigned RESTITUTION_RESET = 19661;

    // pipeline control handed to the arithmetic units
    typedef struct packed {
        logic en;     // whole pipeline advances
        logic valid;  // beat entering the unit is real
    } cpc_ctl_t;

    // the eight kinematic values of one disc pair
    typedef struct packed {
        logic signed [31:0] apx;
        logic signed [31:0] apz;
        logic signed [31:0] avx;
        logic signed [31:0] avz;
        logic signed [31:0] bpx;
        logic signed [31:0] bpz;
        logic signed [31:0] bvx;
        logic signed [31:0] bvz;
    } disc_pair_t;

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [36:0] hi;
        logic signed [36:0] lo;
        hi = 37'sh0_7FFF_FFFF;
        lo = -37'sh0_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // sign and magnitude to two's complement
    function automatic logic signed [36:0] apply_sign(input logic neg,
                                                      input logic [35:0] mag);
        logic signed [36:0] m;
        m = $signed({1'b0, mag});
        return neg ? -m : m;
    endfunction

endpackage

/* hdl/cpc_div.sv */
// ----------------------------------------------------------------------------
// cpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The quotient must be below 2**QW; a side tag travels with each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpc_div #(
    parameter int NW = 59,
    parameter int DW = 39,
    parameter int QW = 34,
    parameter int TW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cpc_pkg::cpc_ctl_t ctl,
    input  logic [NW-1:0]    num,
    input  logic [DW-1:0]    den,
    input  logic [TW-1:0]    tag_in,
    output logic             out_valid,
    output logic [QW-1:0]    quo,
    output logic [TW-1:0]    tag_out
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  rem_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];
    logic [TW-1:0] tag_reg [QW];
    logic          vld_reg [QW];

    generate
        for (genvar s = 0; s < QW; s++) begin : g_stage
            localparam int B = QW - 1 - s;

            logic [W-1:0]  rem_in;
            logic [W-1:0]  dsh;
            logic [W-1:0]  rem_next;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [QW-1:0] quo_next;
            logic [TW-1:0] tag_s;
            logic          vld_in;
            logic          ge;

            // stage inputs
            if (s == 0) begin : g_first
                assign rem_in = W'(num);
                assign den_in = den;
                assign quo_in = '0;
                assign tag_s  = tag_in;
                assign vld_in = ctl.valid;
            end else begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign tag_s  = tag_reg[s-1];
                assign vld_in = vld_reg[s-1];
            end

            // trial subtract of the shifted divisor
            assign dsh      = W'(den_in) << B;
            assign ge       = (rem_in >= dsh);
            assign rem_next = ge ? (rem_in - dsh) : rem_in;
            assign quo_next = {quo_in[QW-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (ctl.en)
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    quo_reg[s] <= quo_next;
                    tag_reg[s] <= tag_s;
                end
            end

            // remainder and divisor are not needed past the last stage
            if (s < QW - 1) begin : g_keep
                always_ff @(posedge clk)
                begin
                    if (ctl.en)
                    begin
                        rem_reg[s] <= rem_next;
                        den_reg[s] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

endmodule

/* hdl/cpc_sqrt.sv */
// ----------------------------------------------------------------------------
// cpc_sqrt
// Pipelined integer square root, floor(sqrt(x)), one root bit per stage.
// A side tag travels with each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpc_sqrt #(
    parameter int XW = 44,
    parameter int TW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cpc_pkg::cpc_ctl_t ctl,
    input  logic [XW-1:0]     x,
    input  logic [TW-1:0]     tag_in,
    output logic              out_valid,
    output logic [XW/2-1:0]   root,
    output logic [TW-1:0]     tag_out
);

    localparam int RW = XW / 2;

    logic [XW-1:0]   x_reg    [RW-1];
    logic [RW+1:0]   rem_reg  [RW-1];
    logic [RW-1:0]   root_reg [RW];
    logic [TW-1:0]   tag_reg  [RW];
    logic            vld_reg  [RW];

    generate
        for (genvar s = 0; s < RW; s++) begin : g_stage
            logic [XW-1:0] x_in;
            logic [XW-1:0] x_next;
            logic [RW+1:0] rem_in;
            logic [RW+1:0] rem_next;
            logic [RW+3:0] remt;
            logic [RW+3:0] trial;
            logic [RW+3:0] rem_full;
            logic [RW-1:0] root_in;
            logic [RW-1:0] root_next;
            logic [TW-1:0] tag_s;
            logic          vld_in;
            logic          ge;

            if (s == 0) begin : g_first
                assign x_in    = x;
                assign rem_in  = '0;
                assign root_in = '0;
                assign tag_s   = tag_in;
                assign vld_in  = ctl.valid;
            end else begin : g_rest
                assign x_in    = x_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
                assign tag_s   = tag_reg[s-1];
                assign vld_in  = vld_reg[s-1];
            end

            // bring in the next two radicand bits, try root*4+1
            assign remt      = {rem_in, x_in[XW-1 -: 2]};
            assign trial     = (RW+4)'({root_in, 2'b01});
            assign ge        = (remt >= trial);
            assign rem_full  = ge ? (remt - trial) : remt;
            assign rem_next  = rem_full[RW+1:0];
            assign root_next = {root_in[RW-2:0], ge};
            assign x_next    = {x_in[XW-3:0], 2'b00};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (ctl.en)
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    root_reg[s] <= root_next;
                    tag_reg[s]  <= tag_s;
                end
            end

            if (s < RW - 1) begin : g_keep
                always_ff @(posedge clk)
                begin
                    if (ctl.en)
                    begin
                        x_reg[s]   <= x_next;
                        rem_reg[s] <= rem_next;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign tag_out   = tag_reg[RW-1];

endmodule

/* hdl/circle_pair_collision.sv */
// ----------------------------------------------------------------------------
// circle_pair_collision
// Collision response for one pair of discs: overlap separation along the
// contact normal and a restitution impulse when the discs approach.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one disc pair per beat; output
//   channel out_valid/out_ready carries the corrected pair plus the touching
//   and impulse_applied flags. cfg_we/cfg_wdata writes the Q1.16 restitution
//   (values above 1.0 clamp to 1.0); write it only while the pipeline is empty.
//   Throughput: one beat per cycle, sustained while the output is not stalled.
//   Depth from the accepting edge to out_valid is set by the chain of
//   bit-per-stage units: 22-stage square root, 34-stage divide (separation
//   shares and normal velocity), then two 35-stage divides (normal
//   projection, mass split), plus the stage registers s1 to s9 and out_reg.
//   Stall: the whole pipeline holds while the output beat waits; in_ready is
//   low only in that case, so nothing is dropped or repeated.
//   Reset: all stages empty, restitution returns to 19661 (about 0.3).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_pair_collision (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] a_pos_x,
    input  logic signed [31:0] a_pos_z,
    input  logic signed [31:0] a_vel_x,
    input  logic signed [31:0] a_vel_z,
    input  logic [20:0]        a_radius,
    input  logic [15:0]        a_mass,
    input  logic signed [31:0] b_pos_x,
    input  logic signed [31:0] b_pos_z,
    input  logic signed [31:0] b_vel_x,
    input  logic signed [31:0] b_vel_z,
    input  logic [20:0]        b_radius,
    input  logic [15:0]        b_mass,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_a_pos_x,
    output logic signed [31:0] new_a_pos_z,
    output logic signed [31:0] new_a_vel_x,
    output logic signed [31:0] new_a_vel_z,
    output logic signed [31:0] new_b_pos_x,
    output logic signed [31:0] new_b_pos_z,
    output logic signed [31:0] new_b_vel_x,
    output logic signed [31:0] new_b_vel_z,
    output logic               touching,
    output logic               impulse_applied,
    input  logic               cfg_we,
    input  logic [16:0]        cfg_wdata
);

    // ------------------------------------------------------------------
    // stage payload types
    // ------------------------------------------------------------------
    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic signed [32:0]  dx;
        logic signed [32:0]  dz;
        logic signed [32:0]  dvx;
        logic signed [32:0]  dvz;
        logic [21:0]         r;
        logic [15:0]         am;
        logic [15:0]         bm;
    } s1_t;

    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic                near;
        logic [42:0]         sqx;
        logic [42:0]         sqz;
        logic [43:0]         rr;
        logic signed [54:0]  pdx;
        logic signed [54:0]  pdz;
        logic signed [21:0]  dx;
        logic signed [21:0]  dz;
        logic [21:0]         r;
        logic [15:0]         am;
        logic [15:0]         bm;
    } s2_t;

    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic                touch;
        logic signed [55:0]  dot;
        logic signed [21:0]  dx;
        logic signed [21:0]  dz;
        logic [21:0]         r;
        logic [15:0]         am;
        logic [15:0]         bm;
    } sq_tag_t;

    typedef struct packed {
        logic [43:0] d2;
        sq_tag_t     tag;
    } s3_t;

    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic                touch;
        logic signed [55:0]  dot;
        logic signed [21:0]  dx;
        logic signed [21:0]  dz;
        logic [21:0]         ov;
        logic [38:0]         den;
        logic [21:0]         d;
        logic [15:0]         am;
        logic [15:0]         bm;
    } s4_t;

    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic                touch;
        logic signed [55:0]  dot;
        logic signed [21:0]  dx;
        logic signed [21:0]  dz;
        logic [38:0]         den;
        logic [21:0]         d;
        logic [15:0]         am;
        logic [15:0]         bm;
        logic signed [43:0]  px;
        logic signed [43:0]  pz;
    } s5_t;

    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic                touch;
        logic                neg;
        logic                sdx;
        logic                sdz;
        logic [21:0]         adx;
        logic [21:0]         adz;
        logic [21:0]         d;
        logic [15:0]         am;
        logic [15:0]         bm;
    } dv_tag_t;

    typedef struct packed {
        logic [58:0] nax;
        logic [58:0] naz;
        logic [58:0] nbx;
        logic [58:0] nbz;
        logic [38:0] den;
        logic [54:0] dotmag;
        logic [21:0] d;
        dv_tag_t     tag;
    } s6_t;

    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic                touch;
        logic                imp;
        logic                neg;
        logic                sdx;
        logic                sdz;
        logic [21:0]         adx;
        logic [21:0]         adz;
        logic [21:0]         d;
        logic [15:0]         am;
        logic [15:0]         bm;
        logic [51:0]         tprod;
    } s7_t;

    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic                touch;
        logic                imp;
        logic                sux;
        logic                suz;
        logic [15:0]         am;
        logic [15:0]         bm;
    } u_tag_t;

    typedef struct packed {
        logic [57:0] nux;
        logic [57:0] nuz;
        logic [21:0] d;
        u_tag_t      tag;
    } s8_t;

    typedef struct packed {
        cpc_pkg::disc_pair_t pv;
        logic                touch;
        logic                imp;
        logic                sux;
        logic                suz;
    } v_tag_t;

    typedef struct packed {
        logic [50:0] nvax;
        logic [50:0] nvaz;
        logic [50:0] nvbx;
        logic [50:0] nvbz;
        logic [16:0] msum;
        v_tag_t      tag;
    } s9_t;

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    logic        adv;
    logic [16:0] restitution_reg;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;
    s7_t s7_reg, s7_next;
    s8_t s8_reg, s8_next;
    s9_t s9_reg, s9_next;

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg;

    cpc_pkg::cpc_ctl_t ctl_sq, ctl_d6, ctl_d8, ctl_d9;

    logic        sq_vld;
    logic [21:0] sq_root;
    sq_tag_t     sq_tag;

    logic        rv_vld;
    logic [33:0] rv_mag, qax, qaz, qbx, qbz;
    dv_tag_t     rv_tag;

    logic        u_vld;
    logic [34:0] ux_mag, uz_mag;
    u_tag_t      u_tag;

    logic        v_vld;
    logic [34:0] qvax, qvaz, qvbx, qvbz;
    v_tag_t      v_tag;

    cpc_pkg::disc_pair_t out_next, out_reg;
    logic                out_valid_reg;
    logic                touching_reg;
    logic                impulse_reg;

    // whole pipeline moves unless the output beat is stuck
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // stage 1: differences, radius sum, mass fixup
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_next.pv.apx = a_pos_x;
        s1_next.pv.apz = a_pos_z;
        s1_next.pv.avx = a_vel_x;
        s1_next.pv.avz = a_vel_z;
        s1_next.pv.bpx = b_pos_x;
        s1_next.pv.bpz = b_pos_z;
        s1_next.pv.bvx = b_vel_x;
        s1_next.pv.bvz = b_vel_z;
        s1_next.dx     = 33'(b_pos_x) - 33'(a_pos_x);
        s1_next.dz     = 33'(b_pos_z) - 33'(a_pos_z);
        s1_next.dvx    = 33'(b_vel_x) - 33'(a_vel_x);
        s1_next.dvz    = 33'(b_vel_z) - 33'(a_vel_z);
        s1_next.r      = 22'(a_radius) + 22'(b_radius);
        s1_next.am     = (a_mass == '0) ? 16'd1 : a_mass;
        s1_next.bm     = (b_mass == '0) ? 16'd1 : b_mass;
    end

    // ------------------------------------------------------------------
    // stage 2: bounding box test, squares, dot product terms
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [32:0] rs;
        logic signed [21:0] dxs;
        logic signed [21:0] dzs;
        logic signed [43:0] sqx_w;
        logic signed [43:0] sqz_w;
        rs    = $signed({11'b0, s1_reg.r});
        dxs   = $signed(s1_reg.dx[21:0]);
        dzs   = $signed(s1_reg.dz[21:0]);
        sqx_w = dxs * dxs;
        sqz_w = dzs * dzs;
        s2_next.pv   = s1_reg.pv;
        s2_next.near = (s1_reg.dx < rs) && (s1_reg.dx > -rs) &&
                       (s1_reg.dz < rs) && (s1_reg.dz > -rs);
        s2_next.sqx  = sqx_w[42:0];
        s2_next.sqz  = sqz_w[42:0];
        s2_next.rr   = s1_reg.r * s1_reg.r;
        s2_next.pdx  = s1_reg.dvx * dxs;
        s2_next.pdz  = s1_reg.dvz * dzs;
        s2_next.dx   = dxs;
        s2_next.dz   = dzs;
        s2_next.r    = s1_reg.r;
        s2_next.am   = s1_reg.am;
        s2_next.bm   = s1_reg.bm;
    end

    // ------------------------------------------------------------------
    // stage 3: squared distance, contact decision, relative dot
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [43:0] d2;
        d2 = 44'(s2_reg.sqx) + 44'(s2_reg.sqz);
        s3_next.d2        = d2;
        s3_next.tag.pv    = s2_reg.pv;
        s3_next.tag.touch = s2_reg.near && (d2 < s2_reg.rr) &&
                            (d2 >= 44'(cpc_pkg::DEGEN_D2));
        s3_next.tag.dot   = 56'(s2_reg.pdx) + 56'(s2_reg.pdz);
        s3_next.tag.dx    = s2_reg.dx;
        s3_next.tag.dz    = s2_reg.dz;
        s3_next.tag.r     = s2_reg.r;
        s3_next.tag.am    = s2_reg.am;
        s3_next.tag.bm    = s2_reg.bm;
    end

    assign ctl_sq = '{en: adv, valid: s3_vld_reg};

    cpc_sqrt #(
        .XW (44),
        .TW ($bits(sq_tag_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_sq),
        .x         (s3_reg.d2),
        .tag_in    (s3_reg.tag),
        .out_valid (sq_vld),
        .root      (sq_root),
        .tag_out   (sq_tag)
    );

    // ------------------------------------------------------------------
    // stage 4: overlap and the separation divisor
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [16:0] msum;
        msum = 17'(sq_tag.am) + 17'(sq_tag.bm);
        s4_next.pv    = sq_tag.pv;
        s4_next.touch = sq_tag.touch;
        s4_next.dot   = sq_tag.dot;
        s4_next.dx    = sq_tag.dx;
        s4_next.dz    = sq_tag.dz;
        s4_next.ov    = sq_tag.r - sq_root;
        s4_next.den   = sq_root * msum;
        s4_next.d     = sq_root;
        s4_next.am    = sq_tag.am;
        s4_next.bm    = sq_tag.bm;
    end

    // ------------------------------------------------------------------
    // stage 5: offset times overlap
    // ------------------------------------------------------------------
    always_comb
    begin
        s5_next.pv    = s4_reg.pv;
        s5_next.touch = s4_reg.touch;
        s5_next.dot   = s4_reg.dot;
        s5_next.dx    = s4_reg.dx;
        s5_next.dz    = s4_reg.dz;
        s5_next.den   = s4_reg.den;
        s5_next.d     = s4_reg.d;
        s5_next.am    = s4_reg.am;
        s5_next.bm    = s4_reg.bm;
        s5_next.px    = s4_reg.dx * $signed({1'b0, s4_reg.ov});
        s5_next.pz    = s4_reg.dz * $signed({1'b0, s4_reg.ov});
    end

    // ------------------------------------------------------------------
    // stage 6: magnitudes and mass weighted dividends
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [43:0] mx_w;
        logic signed [43:0] mz_w;
        logic signed [55:0] dm_w;
        logic signed [21:0] ax_w;
        logic signed [21:0] az_w;
        mx_w = s5_reg.px[43] ? -s5_reg.px : s5_reg.px;
        mz_w = s5_reg.pz[43] ? -s5_reg.pz : s5_reg.pz;
        dm_w = s5_reg.dot[55] ? -s5_reg.dot : s5_reg.dot;
        ax_w = s5_reg.dx[21] ? -s5_reg.dx : s5_reg.dx;
        az_w = s5_reg.dz[21] ? -s5_reg.dz : s5_reg.dz;
        s6_next.nax       = mx_w[42:0] * s5_reg.bm;
        s6_next.naz       = mz_w[42:0] * s5_reg.bm;
        s6_next.nbx       = mx_w[42:0] * s5_reg.am;
        s6_next.nbz       = mz_w[42:0] * s5_reg.am;
        s6_next.den       = s5_reg.den;
        s6_next.dotmag    = dm_w[54:0];
        s6_next.d         = s5_reg.d;
        s6_next.tag.pv    = s5_reg.pv;
        s6_next.tag.touch = s5_reg.touch;
        s6_next.tag.neg   = s5_reg.dot[55];
        s6_next.tag.sdx   = s5_reg.dx[21];
        s6_next.tag.sdz   = s5_reg.dz[21];
        s6_next.tag.adx   = ax_w;
        s6_next.tag.adz   = az_w;
        s6_next.tag.d     = s5_reg.d;
        s6_next.tag.am    = s5_reg.am;
        s6_next.tag.bm    = s5_reg.bm;
    end

    assign ctl_d6 = '{en: adv, valid: s6_vld_reg};

    // normal velocity: |dot| / d, carries the beat tag
    cpc_div #(.NW(55), .DW(22), .QW(34), .TW($bits(dv_tag_t))) u_div_rv (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d6),
        .num (s6_reg.dotmag), .den (s6_reg.d), .tag_in (s6_reg.tag),
        .out_valid (rv_vld), .quo (rv_mag), .tag_out (rv_tag)
    );

    // separation shares, same depth as the normal velocity divide
    cpc_div #(.NW(59), .DW(39), .QW(34), .TW(1)) u_div_ax (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d6),
        .num (s6_reg.nax), .den (s6_reg.den), .tag_in (1'b0),
        .out_valid (), .quo (qax), .tag_out ()
    );

    cpc_div #(.NW(59), .DW(39), .QW(34), .TW(1)) u_div_az (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d6),
        .num (s6_reg.naz), .den (s6_reg.den), .tag_in (1'b0),
        .out_valid (), .quo (qaz), .tag_out ()
    );

    cpc_div #(.NW(59), .DW(39), .QW(34), .TW(1)) u_div_bx (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d6),
        .num (s6_reg.nbx), .den (s6_reg.den), .tag_in (1'b0),
        .out_valid (), .quo (qbx), .tag_out ()
    );

    cpc_div #(.NW(59), .DW(39), .QW(34), .TW(1)) u_div_bz (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d6),
        .num (s6_reg.nbz), .den (s6_reg.den), .tag_in (1'b0),
        .out_valid (), .quo (qbz), .tag_out ()
    );

    // ------------------------------------------------------------------
    // stage 7: apply separation, scale by 1 + restitution
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [17:0] k;
        k = 18'(restitution_reg) + 18'(cpc_pkg::Q16_ONE);
        s7_next.pv = rv_tag.pv;
        if (rv_tag.touch)
        begin
            s7_next.pv.apx = cpc_pkg::sat32(37'(rv_tag.pv.apx) -
                                            cpc_pkg::apply_sign(rv_tag.sdx, 36'(qax)));
            s7_next.pv.apz = cpc_pkg::sat32(37'(rv_tag.pv.apz) -
                                            cpc_pkg::apply_sign(rv_tag.sdz, 36'(qaz)));
            s7_next.pv.bpx = cpc_pkg::sat32(37'(rv_tag.pv.bpx) +
                                            cpc_pkg::apply_sign(rv_tag.sdx, 36'(qbx)));
            s7_next.pv.bpz = cpc_pkg::sat32(37'(rv_tag.pv.bpz) +
                                            cpc_pkg::apply_sign(rv_tag.sdz, 36'(qbz)));
        end
        s7_next.touch = rv_tag.touch;
        s7_next.imp   = rv_tag.touch && rv_tag.neg;
        s7_next.neg   = rv_tag.neg;
        s7_next.sdx   = rv_tag.sdx;
        s7_next.sdz   = rv_tag.sdz;
        s7_next.adx   = rv_tag.adx;
        s7_next.adz   = rv_tag.adz;
        s7_next.d     = rv_tag.d;
        s7_next.am    = rv_tag.am;
        s7_next.bm    = rv_tag.bm;
        s7_next.tprod = rv_mag * k;
    end

    // ------------------------------------------------------------------
    // stage 8: impulse magnitude times offset
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [35:0] tmag;
        tmag = s7_reg.tprod[51:16];
        s8_next.nux       = tmag * s7_reg.adx;
        s8_next.nuz       = tmag * s7_reg.adz;
        s8_next.d         = s7_reg.d;
        s8_next.tag.pv    = s7_reg.pv;
        s8_next.tag.touch = s7_reg.touch;
        s8_next.tag.imp   = s7_reg.imp;
        s8_next.tag.sux   = s7_reg.neg ^ s7_reg.sdx;
        s8_next.tag.suz   = s7_reg.neg ^ s7_reg.sdz;
        s8_next.tag.am    = s7_reg.am;
        s8_next.tag.bm    = s7_reg.bm;
    end

    assign ctl_d8 = '{en: adv, valid: s8_vld_reg};

    // projection of the impulse onto each axis
    cpc_div #(.NW(58), .DW(22), .QW(35), .TW($bits(u_tag_t))) u_div_ux (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d8),
        .num (s8_reg.nux), .den (s8_reg.d), .tag_in (s8_reg.tag),
        .out_valid (u_vld), .quo (ux_mag), .tag_out (u_tag)
    );

    cpc_div #(.NW(58), .DW(22), .QW(35), .TW(1)) u_div_uz (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d8),
        .num (s8_reg.nuz), .den (s8_reg.d), .tag_in (1'b0),
        .out_valid (), .quo (uz_mag), .tag_out ()
    );

    // ------------------------------------------------------------------
    // stage 9: mass weighted impulse dividends
    // ------------------------------------------------------------------
    always_comb
    begin
        s9_next.nvax      = ux_mag * u_tag.bm;
        s9_next.nvaz      = uz_mag * u_tag.bm;
        s9_next.nvbx      = ux_mag * u_tag.am;
        s9_next.nvbz      = uz_mag * u_tag.am;
        s9_next.msum      = 17'(u_tag.am) + 17'(u_tag.bm);
        s9_next.tag.pv    = u_tag.pv;
        s9_next.tag.touch = u_tag.touch;
        s9_next.tag.imp   = u_tag.imp;
        s9_next.tag.sux   = u_tag.sux;
        s9_next.tag.suz   = u_tag.suz;
    end

    assign ctl_d9 = '{en: adv, valid: s9_vld_reg};

    cpc_div #(.NW(51), .DW(17), .QW(35), .TW($bits(v_tag_t))) u_div_vax (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d9),
        .num (s9_reg.nvax), .den (s9_reg.msum), .tag_in (s9_reg.tag),
        .out_valid (v_vld), .quo (qvax), .tag_out (v_tag)
    );

    cpc_div #(.NW(51), .DW(17), .QW(35), .TW(1)) u_div_vaz (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d9),
        .num (s9_reg.nvaz), .den (s9_reg.msum), .tag_in (1'b0),
        .out_valid (), .quo (qvaz), .tag_out ()
    );

    cpc_div #(.NW(51), .DW(17), .QW(35), .TW(1)) u_div_vbx (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d9),
        .num (s9_reg.nvbx), .den (s9_reg.msum), .tag_in (1'b0),
        .out_valid (), .quo (qvbx), .tag_out ()
    );

    cpc_div #(.NW(51), .DW(17), .QW(35), .TW(1)) u_div_vbz (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_d9),
        .num (s9_reg.nvbz), .den (s9_reg.msum), .tag_in (1'b0),
        .out_valid (), .quo (qvbz), .tag_out ()
    );

    // ------------------------------------------------------------------
    // output stage: velocity update
    // ------------------------------------------------------------------
    always_comb
    begin
        out_next = v_tag.pv;
        if (v_tag.imp)
        begin
            out_next.avx = cpc_pkg::sat32(37'(v_tag.pv.avx) +
                                          cpc_pkg::apply_sign(v_tag.sux, 36'(qvax)));
            out_next.avz = cpc_pkg::sat32(37'(v_tag.pv.avz) +
                                          cpc_pkg::apply_sign(v_tag.suz, 36'(qvaz)));
            out_next.bvx = cpc_pkg::sat32(37'(v_tag.pv.bvx) -
                                          cpc_pkg::apply_sign(v_tag.sux, 36'(qvbx)));
            out_next.bvz = cpc_pkg::sat32(37'(v_tag.pv.bvz) -
                                          cpc_pkg::apply_sign(v_tag.suz, 36'(qvbz)));
        end
    end

    // ------------------------------------------------------------------
    // control registers: valid bits, output valid, restitution
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= 17'(cpc_pkg::RESTITUTION_RESET);
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            s3_vld_reg      <= 1'b0;
            s4_vld_reg      <= 1'b0;
            s5_vld_reg      <= 1'b0;
            s6_vld_reg      <= 1'b0;
            s7_vld_reg      <= 1'b0;
            s8_vld_reg      <= 1'b0;
            s9_vld_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                restitution_reg <= (cfg_wdata > 17'(cpc_pkg::Q16_ONE)) ?
                                   17'(cpc_pkg::Q16_ONE) : cfg_wdata;
            end
            if (adv)
            begin
                s1_vld_reg    <= in_valid;
                s2_vld_reg    <= s1_vld_reg;
                s3_vld_reg    <= s2_vld_reg;
                s4_vld_reg    <= sq_vld;
                s5_vld_reg    <= s4_vld_reg;
                s6_vld_reg    <= s5_vld_reg;
                s7_vld_reg    <= rv_vld;
                s8_vld_reg    <= s7_vld_reg;
                s9_vld_reg    <= u_vld;
                out_valid_reg <= v_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            s4_reg       <= s4_next;
            s5_reg       <= s5_next;
            s6_reg       <= s6_next;
            s7_reg       <= s7_next;
            s8_reg       <= s8_next;
            s9_reg       <= s9_next;
            out_reg      <= out_next;
            touching_reg <= v_tag.touch;
            impulse_reg  <= v_tag.imp;
        end
    end

    // output ports
    assign out_valid       = out_valid_reg;
    assign new_a_pos_x     = out_reg.apx;
    assign new_a_pos_z     = out_reg.apz;
    assign new_a_vel_x     = out_reg.avx;
    assign new_a_vel_z     = out_reg.avz;
    assign new_b_pos_x     = out_reg.bpx;
    assign new_b_pos_z     = out_reg.bpz;
    assign new_b_vel_x     = out_reg.bvx;
    assign new_b_vel_z     = out_reg.bvz;
    assign touching        = touching_reg;
    assign impulse_applied = impulse_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "circle_pair_collision_assert.svh"

    `CPC_ASSERT_IMPLY(a_impulse_needs_touch, out_valid_reg, touching_reg || !impulse_reg, "impulse without contact")
    `CPC_ASSERT_NEXT(a_stall_holds_front, !adv, $stable(s1_vld_reg) && $stable(s1_reg), "front stage moved during stall")
    `CPC_ASSERT_ALWAYS(a_restitution_clamped, restitution_reg <= 17'(cpc_pkg::Q16_ONE), "restitution above one")

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Disc pair collision testbench
// Streams disc pairs through circle_pair_collision with random idle gaps on
// the input side and random back-pressure on the output side. A scoreboard
// predicts every response from the accepted pair and the current restitution
// and compares each output beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    // one disc pair as presented on the input ports
    typedef struct {
        logic signed [31:0] apx, apz, avx, avz;
        logic [20:0]        ar;
        logic [15:0]        am;
        logic signed [31:0] bpx, bpz, bvx, bvz;
        logic [20:0]        br;
        logic [15:0]        bm;
    } pair_beat_t;

    // corrected pair plus flags as seen on the output ports
    typedef struct {
        cpc_pkg::disc_pair_t kin;
        logic                touching;
        logic                impulse;
    } response_t;

    localparam int LATENCY = 135;

    // ------------------------------------------------------------------------
    // Scoreboard: collision predictor and queue of expected responses
    // ------------------------------------------------------------------------
    class collision_scoreboard;
        response_t   expected_q[$];
        longint      restitution;
        int          errors;

        function new();
            restitution = cpc_pkg::RESTITUTION_RESET;
            errors      = 0;
        endfunction

        function void set_restitution(logic [16:0] v);
            restitution = (v > cpc_pkg::Q16_ONE) ? cpc_pkg::Q16_ONE : v;
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        // floor of square root, bit by bit
        function longint root_floor(longint x);
            longint res;
            longint b;
            res = 0;
            b   = 64'sd1 <<< 62;
            while (b > x) b = b >>> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >>> 1) + b;
                end else begin
                    res = res >>> 1;
                end
                b = b >>> 2;
            end
            return res;
        endfunction

        function response_t predict_response(pair_beat_t p);
            response_t r;
            longint apx, apz, avx, avz, bpx, bpz, bvx, bvz;
            longint am, bm, dx, dz, rs, d2, d, ov, msum, den, dot, rv, t, ux, uz;
            longint one;
            one = longint'(cpc_pkg::Q16_ONE);
            apx = p.apx; apz = p.apz; avx = p.avx; avz = p.avz;
            bpx = p.bpx; bpz = p.bpz; bvx = p.bvx; bvz = p.bvz;
            am  = (p.am == 0) ? 1 : p.am;
            bm  = (p.bm == 0) ? 1 : p.bm;
            rs  = longint'(p.ar) + longint'(p.br);
            dx  = bpx - apx;
            dz  = bpz - apz;
            r.touching = 0;
            r.impulse  = 0;
            if ((dx < 0 ? -dx : dx) < rs && (dz < 0 ? -dz : dz) < rs) begin
                d2 = dx * dx + dz * dz;
                if (d2 < rs * rs && d2 >= longint'(cpc_pkg::DEGEN_D2)) begin
                    d    = root_floor(d2);
                    ov   = rs - d;
                    msum = am + bm;
                    den  = d * msum;
                    dot  = (bvx - avx) * dx + (bvz - avz) * dz;
                    r.touching = 1;
                    apx = apx - dx * ov * bm / den;
                    apz = apz - dz * ov * bm / den;
                    bpx = bpx + dx * ov * am / den;
                    bpz = bpz + dz * ov * am / den;
                    // approaching: restitution impulse split by mass
                    if (dot < 0) begin
                        rv = dot / d;
                        t  = rv * (one + restitution) / one;
                        ux = t * dx / d;
                        uz = t * dz / d;
                        r.impulse = 1;
                        avx = avx + ux * bm / msum;
                        avz = avz + uz * bm / msum;
                        bvx = bvx - ux * am / msum;
                        bvz = bvz - uz * am / msum;
                    end
                end
            end
            r.kin.apx = clamp32(apx); r.kin.apz = clamp32(apz);
            r.kin.avx = clamp32(avx); r.kin.avz = clamp32(avz);
            r.kin.bpx = clamp32(bpx); r.kin.bpz = clamp32(bpz);
            r.kin.bvx = clamp32(bvx); r.kin.bvz = clamp32(bvz);
            return r;
        endfunction

        function void note_pair(pair_beat_t p);
            expected_q.push_back(predict_response(p));
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_response(response_t got);
            response_t e;
            if (expected_q.size() == 0) begin
                $error("output beat with no pending pair");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp("new_a_pos_x", e.kin.apx, got.kin.apx);
            cmp("new_a_pos_z", e.kin.apz, got.kin.apz);
            cmp("new_a_vel_x", e.kin.avx, got.kin.avx);
            cmp("new_a_vel_z", e.kin.avz, got.kin.avz);
            cmp("new_b_pos_x", e.kin.bpx, got.kin.bpx);
            cmp("new_b_pos_z", e.kin.bpz, got.kin.bpz);
            cmp("new_b_vel_x", e.kin.bvx, got.kin.bvx);
            cmp("new_b_vel_z", e.kin.bvz, got.kin.bvz);
            cmp("touching", e.touching, got.touching);
            cmp("impulse_applied", e.impulse, got.impulse);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic               clk, rst_n;
    logic               in_valid, in_ready, out_valid, out_ready;
    logic signed [31:0] a_pos_x, a_pos_z, a_vel_x, a_vel_z;
    logic signed [31:0] b_pos_x, b_pos_z, b_vel_x, b_vel_z;
    logic [20:0]        a_radius, b_radius;
    logic [15:0]        a_mass, b_mass;
    logic signed [31:0] new_a_pos_x, new_a_pos_z, new_a_vel_x, new_a_vel_z;
    logic signed [31:0] new_b_pos_x, new_b_pos_z, new_b_vel_x, new_b_vel_z;
    logic               touching, impulse_applied;
    logic               cfg_we;
    logic [16:0]        cfg_wdata;

    circle_pair_collision dut (.*);

    collision_scoreboard sb = new();

    int  stall_pct;     // output stall rate, changed per phase
    int  stall_left;

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Beat monitors: note accepted pairs, check accepted responses
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pair_beat_t p;
        response_t  r;
        if (rst_n && in_valid && in_ready)
        begin
            p = '{a_pos_x, a_pos_z, a_vel_x, a_vel_z, a_radius, a_mass,
                  b_pos_x, b_pos_z, b_vel_x, b_vel_z, b_radius, b_mass};
            sb.note_pair(p);
        end
        if (rst_n && out_valid && out_ready)
        begin
            r.kin = '{new_a_pos_x, new_a_pos_z, new_a_vel_x, new_a_vel_z,
                      new_b_pos_x, new_b_pos_z, new_b_vel_x, new_b_vel_z};
            r.touching = touching;
            r.impulse  = impulse_applied;
            sb.check_response(r);
        end
    end

    // gap length: mostly short, a few long
    function automatic int gap_len(int pct);
        int roll;
        roll = $urandom_range(99);
        if (roll >= pct) return 0;
        if (roll < pct / 8) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // output back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            stall_left <= gap_len(stall_pct);
            out_ready  <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_pair(pair_beat_t p, int gap);
        in_valid <= 1'b1;
        a_pos_x <= p.apx; a_pos_z <= p.apz; a_vel_x <= p.avx; a_vel_z <= p.avz;
        a_radius <= p.ar; a_mass <= p.am;
        b_pos_x <= p.bpx; b_pos_z <= p.bpz; b_vel_x <= p.bvx; b_vel_z <= p.bvz;
        b_radius <= p.br; b_mass <= p.bm;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain, let the pipe empty, then write restitution
    task automatic write_restitution(logic [16:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_restitution(v);
    endtask

    function automatic logic signed [31:0] rand_vel();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
            default: return $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23);
        endcase
    endfunction

    function automatic logic [15:0] rand_mass();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(1, 65535));
            1:       return 16'd256;
            default: return 16'($urandom_range(64, 2048));
        endcase
    endfunction

    // random pair, mostly overlapping discs with random content
    function automatic pair_beat_t rand_pair();
        pair_beat_t p;
        longint     rs, ox, oz;
        p.avx = rand_vel(); p.avz = rand_vel();
        p.bvx = rand_vel(); p.bvz = rand_vel();
        p.am  = rand_mass(); p.bm = rand_mass();
        if ($urandom_range(9) == 0)
        begin
            // noise: anything the ports allow
            p.apx = $urandom; p.apz = $urandom; p.bpx = $urandom; p.bpz = $urandom;
            p.ar  = 21'($urandom_range(0, 1 << 20));
            p.br  = 21'($urandom_range(0, 1 << 20));
            return p;
        end
        case ($urandom_range(5))
            0:       begin p.ar = 21'(1 << 20); p.br = 21'($urandom_range(0, 1 << 20)); end
            1:       begin p.ar = 21'($urandom_range(0, 1 << 20)); p.br = 21'(1 << 20); end
            2:       begin p.ar = 21'($urandom_range(0, 64));
                           p.br = 21'($urandom_range(0, 64)); end
            default: begin p.ar = 21'($urandom_range(1, 1 << 17));
                           p.br = 21'($urandom_range(1, 1 << 17)); end
        endcase
        rs = longint'(p.ar) + longint'(p.br);
        ox = longint'($urandom_range(0, 32'(2 * rs))) - rs;
        oz = longint'($urandom_range(0, 32'(2 * rs))) - rs;
        p.apx = $urandom; p.apz = $urandom;
        p.bpx = 32'(longint'(p.apx) + ox);
        p.bpz = 32'(longint'(p.apz) + oz);
        return p;
    endfunction

    function automatic pair_beat_t make_pair(int apx, int apz, int bpx, int bpz,
                                             int ar, int br, int am, int bm,
                                             int avx, int bvx);
        pair_beat_t p;
        p = '{apx, apz, avx, 0, ar[20:0], am[15:0], bpx, bpz, bvx, 0, br[20:0], bm[15:0]};
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pair_beat_t     p;
        logic [16:0]    rest_set[5];
        int             pct;
        rst_n <= 1'b0; in_valid <= 1'b0;
        cfg_we <= 1'b0; cfg_wdata <= '0;
        stall_pct = 0;
        a_pos_x <= 0; a_pos_z <= 0; a_vel_x <= 0; a_vel_z <= 0;
        a_radius <= 0; a_mass <= 1;
        b_pos_x <= 0; b_pos_z <= 0; b_vel_x <= 0; b_vel_z <= 0;
        b_radius <= 0; b_mass <= 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs at reset restitution
        send_pair(make_pair(0, 0, 65536, 0, 65536, 65536, 256, 256, 65536, -65536), 0);
        send_pair(make_pair(0, 0, 65536, 0, 65536, 65536, 256, 256, -65536, 65536), 1);
        send_pair(make_pair(0, 0, 0, 0, 65536, 65536, 256, 256, 5, -5), 0);         // same center
        send_pair(make_pair(0, 0, 6, 0, 65536, 65536, 256, 256, 7, -7), 0);         // d2 below 43
        send_pair(make_pair(0, 0, 6, 3, 65536, 65536, 256, 256, 7, -7), 0);         // d2 at 45
        send_pair(make_pair(0, 0, 5, 0, 0, 0, 256, 256, 7, -7), 2);                 // zero radius
        send_pair(make_pair(0, 0, 1 << 20, 0, 1 << 18, 1 << 18, 256, 256, 9, -9), 0); // far
        send_pair(make_pair(0, 0, 1000, 0, 1 << 20, 1 << 20, 0, 0, 70000, -70000), 0);
        send_pair(make_pair(0, 0, 1000, 500, 1 << 20, 1 << 20, 65535, 1, 1 << 30, 0), 0);
        send_pair(make_pair(32'h7FFF_FF00, 5, 32'h7FFF_FFF0, 5, 1 << 20, 1 << 20,
                            256, 256, 32'h7FFF_FFFF, 32'h8000_0000), 0); // saturate
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0100, 32'h8000_0000,
                            1 << 20, 1 << 20, 1, 65535, 32'h8000_0000, 32'h7FFF_FFFF), 0);
        send_pair(make_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1 << 20, 1 << 20,
                            256, 256, 0, 0), 0);
        send_pair(make_pair(100, 100, 100 + 1000, 100 - 1000, 900, 900, 512, 128,
                            -65536, 65536), 0);

        // restitution phases: reset value, then extremes and random
        rest_set = '{17'd19661, 17'd0, 17'd65536, 17'h1FFFF, 17'($urandom_range(1, 65535))};
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0) write_restitution(rest_set[ph]);
            pct       = (ph == 1) ? 0 : 30;   // one phase with no input idling
            stall_pct = (ph == 2) ? 0 : 25;
            for (int i = 0; i < 340; i++)
            begin
                p = rand_pair();
                send_pair(p, gap_len(pct));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/cpc_pkg.sv
hdl/cpc_div.sv
hdl/cpc_sqrt.sv
hdl/circle_pair_collision.sv
tb/sv/testbench.sv
